@@ rtl/clns_pkg.sv @@
// Package for the character LCD nibble sequencer.
// Holds the control word type, the microcode program and the request decode tables.
// No dependencies.
package clns_pkg;

  localparam int unsigned UcAddrW = 6;
  localparam logic [UcAddrW-1:0] UcInit    = 6'd0;
  localparam logic [UcAddrW-1:0] UcByte    = 6'd29;
  localparam logic [UcAddrW-1:0] UcCursor  = 6'd34;
  localparam logic [UcAddrW-1:0] UcClear   = 6'd35;
  localparam logic [UcAddrW-1:0] UcLast    = 6'd39;

  typedef enum logic [1:0] {
    CMD_INIT   = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_CURSOR = 2'd2,
    CMD_CHAR   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    WAIT_NONE  = 2'd0,
    WAIT_SHORT = 2'd1,
    WAIT_LONG  = 2'd2,
    WAIT_BOTH  = 2'd3
  } wait_e;

  typedef enum logic [1:0] {
    NSEL_IMM = 2'd0,
    NSEL_HI  = 2'd1,
    NSEL_LO  = 2'd2
  } nsel_e;

  typedef enum logic [1:0] {
    RS_OFF  = 2'd0,
    RS_ON   = 2'd1,
    RS_OPND = 2'd2
  } rs_e;

  typedef enum logic [1:0] {
    SEQ_NEXT       = 2'd0,
    SEQ_JUMP       = 2'd1,
    SEQ_END        = 2'd2,
    SEQ_END_IF_CHR = 2'd3
  } seq_e;

  typedef struct packed {
    nsel_e              nsel;
    logic [3:0]         nib;
    rs_e                rs;
    logic               en;
    wait_e              wt;
    seq_e               seq;
    logic [UcAddrW-1:0] tgt;
  } ucode_t;

  typedef struct packed {
    logic   valid;
    logic   last;
    ucode_t uc;
  } issue_t;

  function automatic ucode_t uc_imm(logic en, logic [3:0] nib, wait_e wt, seq_e seq);
    ucode_t w;
    w.nsel = NSEL_IMM;
    w.nib  = nib;
    w.rs   = RS_OFF;
    w.en   = en;
    w.wt   = wt;
    w.seq  = seq;
    w.tgt  = '0;
    return w;
  endfunction

  function automatic ucode_t uc_opnd(nsel_e nsel, logic en, wait_e wt, seq_e seq);
    ucode_t w;
    w.nsel = nsel;
    w.nib  = 4'h0;
    w.rs   = RS_OPND;
    w.en   = en;
    w.wt   = wt;
    w.seq  = seq;
    w.tgt  = '0;
    return w;
  endfunction

  function automatic ucode_t ucode_rom(logic [UcAddrW-1:0] addr);
    ucode_t w;
    w = uc_imm(1'b0, 4'h0, WAIT_NONE, SEQ_END);
    case (addr)
      6'd0:  w = uc_imm(1'b0, 4'h0, WAIT_NONE,  SEQ_NEXT);
      6'd1:  w = uc_imm(1'b1, 4'h3, WAIT_NONE,  SEQ_NEXT);
      6'd2:  w = uc_imm(1'b0, 4'h3, WAIT_LONG,  SEQ_NEXT);
      6'd3:  w = uc_imm(1'b1, 4'h3, WAIT_NONE,  SEQ_NEXT);
      6'd4:  w = uc_imm(1'b0, 4'h3, WAIT_LONG,  SEQ_NEXT);
      6'd5:  w = uc_imm(1'b1, 4'h3, WAIT_NONE,  SEQ_NEXT);
      6'd6:  w = uc_imm(1'b0, 4'h3, WAIT_LONG,  SEQ_NEXT);
      6'd7:  w = uc_imm(1'b1, 4'h2, WAIT_NONE,  SEQ_NEXT);
      6'd8:  w = uc_imm(1'b0, 4'h2, WAIT_NONE,  SEQ_NEXT);
      6'd9:  w = uc_imm(1'b0, 4'h0, WAIT_NONE,  SEQ_NEXT);
      6'd10: w = uc_imm(1'b1, 4'h0, WAIT_NONE,  SEQ_NEXT);
      6'd11: w = uc_imm(1'b0, 4'h0, WAIT_NONE,  SEQ_NEXT);
      6'd12: w = uc_imm(1'b1, 4'h1, WAIT_NONE,  SEQ_NEXT);
      6'd13: w = uc_imm(1'b0, 4'h1, WAIT_BOTH,  SEQ_NEXT);
      6'd14: w = uc_imm(1'b0, 4'h0, WAIT_NONE,  SEQ_NEXT);
      6'd15: w = uc_imm(1'b1, 4'h0, WAIT_NONE,  SEQ_NEXT);
      6'd16: w = uc_imm(1'b0, 4'h0, WAIT_NONE,  SEQ_NEXT);
      6'd17: w = uc_imm(1'b1, 4'h6, WAIT_NONE,  SEQ_NEXT);
      6'd18: w = uc_imm(1'b0, 4'h6, WAIT_BOTH,  SEQ_NEXT);
      6'd19: w = uc_imm(1'b0, 4'h0, WAIT_NONE,  SEQ_NEXT);
      6'd20: w = uc_imm(1'b1, 4'h0, WAIT_NONE,  SEQ_NEXT);
      6'd21: w = uc_imm(1'b0, 4'h0, WAIT_NONE,  SEQ_NEXT);
      6'd22: w = uc_imm(1'b1, 4'hC, WAIT_NONE,  SEQ_NEXT);
      6'd23: w = uc_imm(1'b0, 4'hC, WAIT_SHORT, SEQ_NEXT);
      6'd24: w = uc_imm(1'b0, 4'h0, WAIT_NONE,  SEQ_NEXT);
      6'd25: w = uc_imm(1'b1, 4'h2, WAIT_NONE,  SEQ_NEXT);
      6'd26: w = uc_imm(1'b0, 4'h2, WAIT_NONE,  SEQ_NEXT);
      6'd27: w = uc_imm(1'b1, 4'h8, WAIT_NONE,  SEQ_NEXT);
      6'd28: w = uc_imm(1'b0, 4'h8, WAIT_SHORT, SEQ_END);
      6'd29: w = uc_opnd(NSEL_HI, 1'b1, WAIT_NONE,  SEQ_NEXT);
      6'd30: w = uc_opnd(NSEL_HI, 1'b0, WAIT_NONE,  SEQ_NEXT);
      6'd31: w = uc_opnd(NSEL_LO, 1'b1, WAIT_NONE,  SEQ_NEXT);
      6'd32: w = uc_opnd(NSEL_LO, 1'b0, WAIT_SHORT, SEQ_END_IF_CHR);
      6'd33: begin
        w    = uc_imm(1'b0, 4'h0, WAIT_NONE, SEQ_END);
        w.rs = RS_ON;
      end
      6'd34: begin
        w     = uc_imm(1'b0, 4'h0, WAIT_NONE, SEQ_JUMP);
        w.tgt = UcByte;
      end
      6'd35: w = uc_imm(1'b0, 4'h0, WAIT_NONE,  SEQ_NEXT);
      6'd36: w = uc_imm(1'b1, 4'h0, WAIT_NONE,  SEQ_NEXT);
      6'd37: w = uc_imm(1'b0, 4'h0, WAIT_NONE,  SEQ_NEXT);
      6'd38: w = uc_imm(1'b1, 4'h1, WAIT_NONE,  SEQ_NEXT);
      6'd39: w = uc_imm(1'b0, 4'h1, WAIT_BOTH,  SEQ_END);
      default: w = uc_imm(1'b0, 4'h0, WAIT_NONE, SEQ_END);
    endcase
    return w;
  endfunction

  function automatic logic [UcAddrW-1:0] cmd_entry(cmd_e cmd);
    logic [UcAddrW-1:0] a;
    unique case (cmd)
      CMD_INIT:   a = UcInit;
      CMD_CLEAR:  a = UcClear;
      CMD_CURSOR: a = UcCursor;
      CMD_CHAR:   a = UcByte;
      default:    a = UcInit;
    endcase
    return a;
  endfunction

  function automatic logic [7:0] row_base(logic [1:0] row);
    logic [7:0] b;
    unique case (row)
      2'd0:    b = 8'h00;
      2'd1:    b = 8'h40;
      2'd2:    b = 8'h14;
      2'd3:    b = 8'h54;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

@@ rtl/clns_datapath.sv @@
// Operand store and port byte formation for the LCD nibble sequencer.
// Driven one control word per cycle by the sequencer; depends on clns_pkg.
module clns_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic [1:0]        cmd_i,
  input  logic [1:0]        row_i,
  input  logic [5:0]        column_i,
  input  logic [7:0]        character_i,
  input  clns_pkg::issue_t  issue_i,
  output logic              chr_o,
  output logic [7:0]        port_value_o,
  output logic [1:0]        wait_after_o,
  output logic              last_o,
  output logic              strobe_o
);
  import clns_pkg::*;

  logic [7:0] op_q, op_d;
  logic       chr_q, chr_d;
  logic       strobe_q;
  logic [7:0] port_q, port_d;
  logic [1:0] wait_q;
  logic       last_q;
  logic [3:0] nib;
  logic       rs;
  logic [7:0] addr;

  always_comb begin
    addr = (row_base(row_i) + {2'b00, column_i}) | 8'h80;
    chr_d = (cmd_e'(cmd_i) == CMD_CHAR);
    op_d  = chr_d ? character_i : addr;
  end

  always_comb begin
    unique case (issue_i.uc.nsel)
      NSEL_HI: nib = op_q[7:4];
      NSEL_LO: nib = op_q[3:0];
      default: nib = issue_i.uc.nib;
    endcase
    unique case (issue_i.uc.rs)
      RS_ON:   rs = 1'b1;
      RS_OPND: rs = chr_q;
      default: rs = 1'b0;
    endcase
    port_d = {2'b00, issue_i.uc.en, rs, nib};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
      chr_q    <= 1'b0;
    end else begin
      strobe_q <= issue_i.valid;
      if (load_i) begin
        chr_q <= chr_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      op_q <= op_d;
    end
    if (issue_i.valid) begin
      port_q <= port_d;
      wait_q <= issue_i.uc.wt;
      last_q <= issue_i.last;
    end
  end

  assign chr_o        = chr_q;
  assign port_value_o = port_q;
  assign wait_after_o = wait_q;
  assign last_o       = last_q;
  assign strobe_o     = strobe_q;

endmodule

@@ rtl/char_lcd_nibble_sequencer.sv @@
// Character LCD nibble sequencer, top level: microcode step counter and program.
// Start loads the busy flag and step counter; each step is registered onto the outputs.
// Throughput: one port write per cycle while a request runs, set by the single microcode
// step issued per cycle; busy drops on the final step.
// Reset: idle, no strobe; the receiver takes every strobed write and cannot stall.
// Depends on clns_pkg and clns_datapath.
module char_lcd_nibble_sequencer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] cmd_i,
  input  logic [1:0] row_i,
  input  logic [5:0] column_i,
  input  logic [7:0] character_i,
  output logic [7:0] port_value_o,
  output logic [1:0] wait_after_o,
  output logic       last_o,
  output logic       strobe_o
);
  import clns_pkg::*;

  logic               busy_q, busy_d;
  logic [UcAddrW-1:0] pc_q, pc_d;
  ucode_t             uc;
  issue_t             issue;
  logic               chr;
  logic               fin;
  logic               accept;

  always_comb begin
    uc     = ucode_rom(pc_q);
    fin    = busy_q && ((uc.seq == SEQ_END) || ((uc.seq == SEQ_END_IF_CHR) && chr));
    busy   = busy_q && !fin;
    accept = start && !busy;

    issue.valid = busy_q;
    issue.last  = fin;
    issue.uc    = uc;

    busy_d = busy_q;
    pc_d   = pc_q;
    if (accept) begin
      busy_d = 1'b1;
      pc_d   = cmd_entry(cmd_e'(cmd_i));
    end else if (fin) begin
      busy_d = 1'b0;
    end else if (busy_q) begin
      pc_d = (uc.seq == SEQ_JUMP) ? uc.tgt : pc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= '0;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
    end
  end

  clns_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (accept),
    .cmd_i        (cmd_i),
    .row_i        (row_i),
    .column_i     (column_i),
    .character_i  (character_i),
    .issue_i      (issue),
    .chr_o        (chr),
    .port_value_o (port_value_o),
    .wait_after_o (wait_after_o),
    .last_o       (last_o),
    .strobe_o     (strobe_o)
  );

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q)
    else $error("sequencer not running after start transfer");

  a_strobe_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |=> !strobe_o)
    else $error("port write strobed with no step issued");

  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (pc_q <= UcLast))
    else $error("step counter outside program");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && fin) |=> (strobe_o && last_o))
    else $error("final step not marked last");

endmodule

@@ dv/tb_char_lcd_nibble_sequencer.sv @@
// Testbench for char_lcd_nibble_sequencer: drives init, clear, set cursor and character requests
// and checks every strobed port write against a predicted queue held in a scoreboard class.
// Depends on clns_pkg and the char_lcd_nibble_sequencer RTL.
`timescale 1ns / 100ps

module tb_char_lcd_nibble_sequencer;
  import clns_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned NumRandom     = 460;
  localparam int unsigned TailCycles    = 40;

  localparam logic [7:0] PortRs         = 8'h10;
  localparam logic [7:0] PortE          = 8'h20;
  localparam logic [7:0] LcdWake        = 8'h03;
  localparam logic [7:0] LcdFourBit     = 8'h02;
  localparam logic [7:0] LcdClear       = 8'h01;
  localparam logic [7:0] LcdEntryMode   = 8'h06;
  localparam logic [7:0] LcdDisplayOn   = 8'h0C;
  localparam logic [7:0] LcdFunctionSet = 8'h28;
  localparam logic [7:0] LcdSetAddr     = 8'h80;

  typedef struct packed {
    logic [7:0] port_value;
    wait_e      wait_after;
    logic       last;
  } port_write_t;

  class lcd_port_scoreboard;
    port_write_t writes_q[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned per_cmd[4];
    logic [7:0]  row_offset[4];

    function new();
      row_offset = '{8'h00, 8'h40, 8'h14, 8'h54};
      errors     = 0;
      checked    = 0;
      per_cmd    = '{0, 0, 0, 0};
    endfunction

    function void push_write(logic [7:0] pv, wait_e wt);
      port_write_t w;
      w.port_value = pv;
      w.wait_after = wt;
      w.last       = 1'b0;
      writes_q.push_back(w);
    endfunction

    function void push_pulse(logic [7:0] bits, wait_e wt);
      push_write(bits | PortE, WAIT_NONE);
      push_write(bits & ~PortE, wt);
    endfunction

    function void push_byte(logic [7:0] c, wait_e wt);
      push_write(8'h00, WAIT_NONE);
      push_pulse({4'h0, c[7:4]}, WAIT_NONE);
      push_pulse({4'h0, c[3:0]}, wt);
    endfunction

    function void note_request(cmd_e cmd, logic [1:0] row, logic [5:0] column,
                               logic [7:0] character);
      logic [7:0]  addr;
      port_write_t w;
      per_cmd[cmd]++;
      case (cmd)
        CMD_INIT: begin
          push_write(8'h00, WAIT_NONE);
          repeat (3) push_pulse(LcdWake, WAIT_LONG);
          push_pulse(LcdFourBit, WAIT_NONE);
          push_byte(LcdClear, WAIT_BOTH);
          push_byte(LcdEntryMode, WAIT_BOTH);
          push_byte(LcdDisplayOn, WAIT_SHORT);
          push_byte(LcdFunctionSet, WAIT_SHORT);
        end
        CMD_CLEAR: begin
          push_byte(LcdClear, WAIT_BOTH);
        end
        CMD_CURSOR: begin
          addr = (row_offset[row] + {2'b00, column}) | LcdSetAddr;
          push_byte(addr, WAIT_SHORT);
          push_write(PortRs, WAIT_NONE);
        end
        default: begin
          push_pulse({4'h0, character[7:4]} | PortRs, WAIT_NONE);
          push_pulse({4'h0, character[3:0]} | PortRs, WAIT_SHORT);
        end
      endcase
      w      = writes_q.pop_back();
      w.last = 1'b1;
      writes_q.push_back(w);
    endfunction

    function void check_write(logic [7:0] pv, logic [1:0] wt, logic last);
      port_write_t w;
      if (writes_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected port write %02h, nothing pending", $time, pv);
        return;
      end
      w = writes_q.pop_front();
      checked++;
      if (pv !== w.port_value) begin
        errors++;
        $display("%0t: port_value expected %02h actual %02h", $time, w.port_value, pv);
      end
      if (wt !== w.wait_after) begin
        errors++;
        $display("%0t: wait_after expected %0d actual %0d", $time, w.wait_after, wt);
      end
      if (last !== w.last) begin
        errors++;
        $display("%0t: last expected %0b actual %0b", $time, w.last, last);
      end
    endfunction
  endclass

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       start       = 1'b0;
  logic [1:0] cmd_i       = 2'd0;
  logic [1:0] row_i       = 2'd0;
  logic [5:0] column_i    = 6'd0;
  logic [7:0] character_i = 8'd0;
  logic       busy;
  logic [7:0] port_value_o;
  logic [1:0] wait_after_o;
  logic       last_o;
  logic       strobe_o;

  lcd_port_scoreboard sb = new();
  int unsigned        stall_count = 0;

  char_lcd_nibble_sequencer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .row_i       (row_i),
    .column_i    (column_i),
    .character_i (character_i),
    .port_value_o(port_value_o),
    .wait_after_o(wait_after_o),
    .last_o      (last_o),
    .strobe_o    (strobe_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && strobe_o) begin
      sb.check_write(port_value_o, wait_after_o, last_o);
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || strobe_o) begin
      stall_count <= 0;
    end else begin
      stall_count <= stall_count + 1;
    end
    if (stall_count >= WatchdogLimit) begin
      $display("[char_lcd_nibble_sequencer] ERROR");
      $finish;
    end
  end

  task automatic send_request(cmd_e c, logic [1:0] r, logic [5:0] col, logic [7:0] ch);
    cmd_i       <= c;
    row_i       <= r;
    column_i    <= col;
    character_i <= ch;
    start       <= 1'b1;
    do @(posedge clk_i); while (busy !== 1'b0);
    sb.note_request(c, r, col, ch);
  endtask

  task automatic idle_cycles(int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.writes_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic random_request();
    int unsigned sel;
    cmd_e        c;
    logic [5:0]  col;
    sel = $urandom_range(99);
    if (sel < 6) begin
      c = CMD_INIT;
    end else if (sel < 26) begin
      c = CMD_CLEAR;
    end else if (sel < 60) begin
      c = CMD_CURSOR;
    end else begin
      c = CMD_CHAR;
    end
    col = ($urandom_range(99) < 85) ? 6'($urandom_range(39)) : 6'($urandom_range(63, 40));
    send_request(c, 2'($urandom_range(3)), col, 8'($urandom_range(255)));
  endtask

  initial begin
    int unsigned r;
    bit          quiet;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(CMD_INIT, 2'd0, 6'd0, 8'h00);
    send_request(CMD_CLEAR, 2'd3, 6'd63, 8'hFF);
    for (int unsigned row = 0; row < 4; row++) begin
      send_request(CMD_CURSOR, 2'(row), 6'd0, 8'h00);
      send_request(CMD_CURSOR, 2'(row), 6'd39, 8'h00);
      idle_cycles(row + 1);
      send_request(CMD_CURSOR, 2'(row), 6'd63, 8'hFF);
    end
    send_request(CMD_CHAR, 2'd0, 6'd0, 8'h00);
    send_request(CMD_CHAR, 2'd0, 6'd0, 8'hFF);
    send_request(CMD_CHAR, 2'd0, 6'd0, 8'h7F);
    send_request(CMD_CHAR, 2'd0, 6'd0, 8'h80);
    send_request(CMD_CHAR, 2'd3, 6'd63, 8'h5A);
    send_request(CMD_CHAR, 2'd0, 6'd0, 8'hA5);
    send_request(CMD_INIT, 2'd3, 6'd63, 8'hFF);
    drain();

    for (int unsigned i = 0; i < NumRandom; i++) begin
      quiet = (i >= 150) && (i < 260);
      if (!quiet) begin
        r = $urandom_range(99);
        if (r < 23) begin
          idle_cycles($urandom_range(6, 1));
        end else if (r < 26) begin
          idle_cycles($urandom_range(34, 7));
        end
        if (i % 97 == 50) begin
          drain();
        end
      end
      random_request();
    end

    drain();
    repeat (TailCycles) @(posedge clk_i);

    $display("Covered %0d requests: %0d init, %0d clear, %0d set cursor, %0d character.",
             sb.per_cmd[CMD_INIT] + sb.per_cmd[CMD_CLEAR] + sb.per_cmd[CMD_CURSOR] +
             sb.per_cmd[CMD_CHAR], sb.per_cmd[CMD_INIT], sb.per_cmd[CMD_CLEAR],
             sb.per_cmd[CMD_CURSOR], sb.per_cmd[CMD_CHAR]);
    $display("Checked %0d port writes, %0d mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.writes_q.size() == 0) begin
      $display("[char_lcd_nibble_sequencer] OK");
    end else begin
      $display("[char_lcd_nibble_sequencer] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/clns_pkg.sv
rtl/clns_datapath.sv
rtl/char_lcd_nibble_sequencer.sv
dv/tb_char_lcd_nibble_sequencer.sv
